// ===== rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants of the sector cache tag engine
// entry layout, command codes, controller states and the
// controller/datapath command and status bundles
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int MAX_RESULTS = 64;
  localparam int TAG_W       = 32;
  localparam int SLOT_W      = 6;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IN_W        = 40;
  localparam int OUT_W       = 48;
  localparam int OUT_PAD     = OUT_W - (TAG_W + SLOT_W + 3);

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic             accessed;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LK_RD,
    S_LK_EV,
    S_VC_RD,
    S_VC_EV,
    S_FL_RD,
    S_FL_EV,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    WR_ZERO,
    WR_HIT,
    WR_FILL,
    WR_AGE,
    WR_CLEAN
  } wr_sel_t;

  typedef enum logic [1:0] {
    PEND_HOLD,
    PEND_HIT,
    PEND_MISS,
    PEND_FLUSH
  } pend_sel_t;

  typedef struct packed {
    logic      req_load;
    logic      idx_inc;
    logic      n_inc;
    logic      use_hand;
    logic      hand_inc;
    logic      ram_we;
    wr_sel_t   wr_sel;
    pend_sel_t pend_sel;
    logic      out_push;
    logic      out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic n_cap;
    logic tag_match;
    logic ent_valid;
    logic ent_dirty;
    logic ent_accessed;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/scc_ram.sv =====
// ----------------------------------------------------------------------------
// scc_ram: generic single write port, single read port ram
// read data registered, so reads have registered rather than combinational latency
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scc_datapath.sv =====
// ----------------------------------------------------------------------------
// scc_datapath: entry ram, scan index, clock hand, pending result and
// output register
// ----------------------------------------------------------------------------
module scc_datapath
  import scc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       in_cmd,
  input  logic [TAG_W-1:0] in_sector,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_data,
  output logic             out_last
);

  logic [IW-1:0]      idx;
  logic [IW-1:0]      hand;
  logic [CNT_W-1:0]   n;
  logic [TAG_W-1:0]   req_sector;
  logic               req_write;
  logic               pend_valid;
  logic               pend_hit;
  logic [SLOT_W-1:0]  pend_slot;
  logic               pend_fill;
  logic               pend_wb;
  logic [TAG_W-1:0]   pend_wbs;
  logic [IW-1:0]      addr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd;
  entry_t             wdata;
  logic               idx_last;
  logic               hand_last;

  assign addr      = cmd.use_hand ? hand : idx;
  assign rd        = entry_t'(ram_rdata);
  assign idx_last  = (idx == IW'(ENTRIES - 1));
  assign hand_last = (hand == IW'(ENTRIES - 1));

  scc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(addr),
    .wdata(wdata),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    wdata = rd;
    case (cmd.wr_sel)
      WR_ZERO: begin
        wdata = '0;
      end
      WR_HIT: begin
        wdata.dirty    = rd.dirty | req_write;
        wdata.accessed = 1'b1;
      end
      WR_FILL: begin
        wdata.valid    = 1'b1;
        wdata.dirty    = req_write;
        wdata.accessed = 1'b1;
        wdata.tag      = req_sector;
      end
      WR_AGE: begin
        wdata.accessed = 1'b0;
      end
      WR_CLEAN: begin
        wdata.dirty = 1'b0;
      end
      default: begin
        wdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      hand <= '0;
      n    <= '0;
    end else begin
      if (cmd.req_load) begin
        idx <= '0;
        n   <= '0;
      end else begin
        if (cmd.idx_inc) begin
          idx <= idx_last ? '0 : idx + 1'b1;
        end
        if (cmd.n_inc) begin
          n <= n + 1'b1;
        end
      end
      if (cmd.hand_inc) begin
        hand <= hand_last ? '0 : hand + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_sector <= in_sector;
      req_write  <= (in_cmd == CMD_WRITE);
    end
  end

  // pending result: held back until the next one is known, so last can be set
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.req_load) begin
      pend_valid <= 1'b0;
    end else if (cmd.pend_sel != PEND_HOLD) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      pend_hit  <= 1'b0;
      pend_slot <= '0;
      pend_fill <= 1'b0;
      pend_wb   <= 1'b0;
      pend_wbs  <= '0;
    end else begin
      case (cmd.pend_sel)
        PEND_HIT: begin
          pend_hit  <= 1'b1;
          pend_slot <= SLOT_W'(idx);
          pend_fill <= 1'b0;
          pend_wb   <= 1'b0;
          pend_wbs  <= '0;
        end
        PEND_MISS: begin
          pend_hit  <= 1'b0;
          pend_slot <= SLOT_W'(hand);
          pend_fill <= 1'b1;
          pend_wb   <= rd.valid & rd.dirty;
          pend_wbs  <= (rd.valid & rd.dirty) ? rd.tag : '0;
        end
        PEND_FLUSH: begin
          pend_hit  <= 1'b0;
          pend_slot <= SLOT_W'(idx);
          pend_fill <= 1'b0;
          pend_wb   <= 1'b1;
          pend_wbs  <= rd.tag;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) begin
      out_data <= {{OUT_PAD{1'b0}}, pend_wbs, pend_wb, pend_fill, pend_slot, pend_hit};
      out_last <= cmd.out_last;
    end
  end

  always_comb begin
    stat.idx_last     = idx_last;
    stat.n_cap        = (n == CNT_W'(MAX_RESULTS - 1));
    stat.tag_match    = rd.valid && (rd.tag == req_sector);
    stat.ent_valid    = rd.valid;
    stat.ent_dirty    = rd.dirty;
    stat.ent_accessed = rd.accessed;
    stat.pend_valid   = pend_valid;
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

// ===== rtl/scc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scc_ctrl: sequencer for clearing, lookup, clock sweep and flush
// one ram read state and one evaluate state per entry
// ----------------------------------------------------------------------------
module scc_ctrl
  import scc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   accept;
  logic   fl_dirty;
  logic   fl_stall;
  logic   fl_stop;
  logic   victim;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fl_dirty = stat.ent_valid && stat.ent_dirty;
  assign fl_stall = fl_dirty && stat.pend_valid && !stat.out_free;
  assign fl_stop  = stat.n_cap || stat.idx_last;
  assign victim   = !stat.ent_valid || !stat.ent_accessed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.idx_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_FLUSH: state_next = S_FL_RD;
            CMD_NONE:  state_next = S_IDLE;
            default:   state_next = S_LK_RD;
          endcase
        end
      end
      S_LK_RD: state_next = S_LK_EV;
      S_LK_EV: begin
        if (stat.tag_match) state_next = S_EMIT;
        else if (stat.idx_last) state_next = S_VC_RD;
        else state_next = S_LK_RD;
      end
      S_VC_RD: state_next = S_VC_EV;
      S_VC_EV: begin
        state_next = victim ? S_EMIT : S_VC_RD;
      end
      S_FL_RD: state_next = S_FL_EV;
      S_FL_EV: begin
        if (fl_dirty) begin
          if (!fl_stall) state_next = fl_stop ? S_EMIT : S_FL_RD;
        end else begin
          state_next = stat.idx_last ? S_EMIT : S_FL_RD;
        end
      end
      S_EMIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.wr_sel   = WR_ZERO;
    cmd.pend_sel = PEND_HOLD;
    unique case (state)
      S_CLEAR: begin
        cmd.ram_we  = 1'b1;
        cmd.wr_sel  = WR_ZERO;
        cmd.idx_inc = !stat.idx_last;
      end
      S_IDLE: begin
        cmd.req_load = accept;
      end
      S_LK_RD: begin
      end
      S_LK_EV: begin
        if (stat.tag_match) begin
          cmd.ram_we   = 1'b1;
          cmd.wr_sel   = WR_HIT;
          cmd.pend_sel = PEND_HIT;
        end else begin
          cmd.idx_inc = !stat.idx_last;
        end
      end
      S_VC_RD: begin
        cmd.use_hand = 1'b1;
      end
      S_VC_EV: begin
        // second chance: an accessed entry is aged and passed over
        cmd.use_hand = 1'b1;
        cmd.ram_we   = 1'b1;
        cmd.hand_inc = 1'b1;
        if (victim) begin
          cmd.wr_sel   = WR_FILL;
          cmd.pend_sel = PEND_MISS;
        end else begin
          cmd.wr_sel = WR_AGE;
        end
      end
      S_FL_RD: begin
      end
      S_FL_EV: begin
        if (fl_dirty) begin
          if (!fl_stall) begin
            cmd.out_push = stat.pend_valid;
            cmd.ram_we   = 1'b1;
            cmd.wr_sel   = WR_CLEAN;
            cmd.pend_sel = PEND_FLUSH;
            cmd.n_inc    = 1'b1;
            cmd.idx_inc  = !fl_stop;
          end
        end else begin
          cmd.idx_inc = !stat.idx_last;
        end
      end
      S_EMIT: begin
        cmd.out_push = stat.out_free;
        cmd.out_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/sector_cache_clock_replacement.sv =====
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement: tag and clock replacement engine of a
// fully associative write-back sector cache
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  cmd, sector
// m_*      out  m_tvalid/m_tready  hit, slot, fill, writeback, sector, last
//
// entries live in one ram, each visited by a read state and an evaluate state
// read/write: a hit ends the scan; a miss scans every entry, then the hand
// passes at most ENTRIES+1 entries; flush: one result per dirty entry, at most
// MAX_RESULTS (one empty result if none is dirty), and output stalls can hold it
// after reset a clearing pass over all entries runs with s_tready low
// a finished result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
module sector_cache_clock_replacement
  import scc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // cmd[1:0], sector[33:2], zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // hit[0], slot[6:1], fill[7], writeback[8],
                                      // writeback_sector[40:9], zero pad
  output logic             m_tlast
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  scc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_cmd  (s_tdata[1:0]),
    .in_ready(s_tready),
    .stat    (dp_stat),
    .cmd     (dp_cmd)
  );

  scc_datapath #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_cmd   (s_tdata[1:0]),
    .in_sector(s_tdata[TAG_W+1:2]),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_data (m_tdata),
    .out_last (m_tlast)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tdata[1:0] != CMD_NONE)) |=> !s_tready)
    else $error("item accepted while a request is still in progress");

  // a result is only loaded when the output register is free
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.out_push |-> dp_stat.out_free)
    else $error("result overwrote one not yet taken");

  // a hit never needs a fill or a writeback
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (!m_tdata[7] && !m_tdata[8]))
    else $error("hit result asks for fill or writeback");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sector cache clock replacement engine
// a short table of directed requests, then random read/write/flush traffic
// over a sector pool larger than the cache, then a pass that dirties every
// entry ahead of a full flush and more random traffic; results are checked
// against table values or a bench model of tag, dirty, accessed bits and hand
// ----------------------------------------------------------------------------
module tb
  import scc_pkg::*;
;

  localparam int NUM_ENTRIES = ENTRIES_DEF;
  localparam int SECTOR_POOL = 80;
  localparam int LONG_HOLD   = 1500;
  localparam int MAX_REPORTS = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 300;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fill;
    logic              writeback;
    logic [TAG_W-1:0]  wb_sector;
    logic              last;
  } cache_reply_t;

  // how a table row gets its expected result
  typedef enum logic [1:0] {
    KIND_MODEL,
    KIND_NONE,
    KIND_FIXED
  } row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [1:0]   cmd;
    logic [31:0]  sector;
    cache_reply_t reply;
  } table_row_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE
  } ready_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  // shadow of the cache state
  bit               line_valid [NUM_ENTRIES];
  bit               line_dirty [NUM_ENTRIES];
  bit               line_ref   [NUM_ENTRIES];
  logic [TAG_W-1:0] line_sector[NUM_ENTRIES];
  int               sweep_pos = 0;

  cache_reply_t step_out[MAX_RESULTS];
  int           step_n;
  cache_reply_t replies_due[$];
  table_row_t   directed_rows[$];
  logic [31:0]  sector_pool[SECTOR_POOL];

  int mismatches  = 0;
  int cycle_count = 0;
  int holds_asked = 0;
  int holds_done  = 0;
  int burst_left  = 0;

  sector_cache_clock_replacement dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic cache_reply_t make_reply(input logic hit, input int slot, input logic fill,
                                              input logic wb, input logic [31:0] wbs,
                                              input logic last);
    cache_reply_t r;
    r.hit       = hit;
    r.slot      = SLOT_W'(slot);
    r.fill      = fill;
    r.writeback = wb;
    r.wb_sector = wbs;
    r.last      = last;
    return r;
  endfunction

  // works out the results of one accepted request and updates the shadow
  task automatic predict_request(input logic [1:0] cmd, input logic [31:0] sector);
    int  idx;
    int  way;
    bit  hit;
    bit  wb;
    logic [31:0] wbs;
    step_n = 0;
    case (cmd)
      CMD_FLUSH: begin
        for (idx = 0; idx < NUM_ENTRIES && step_n < MAX_RESULTS; idx++) begin
          if (line_valid[idx] && line_dirty[idx]) begin
            step_out[step_n] = make_reply(1'b0, idx, 1'b0, 1'b1, line_sector[idx], 1'b0);
            line_dirty[idx] = 1'b0;
            step_n++;
          end
        end
        if (step_n == 0) begin
          step_out[0] = make_reply(1'b0, 0, 1'b0, 1'b0, 32'd0, 1'b1);
          step_n = 1;
        end else begin
          step_out[step_n-1].last = 1'b1;
        end
      end
      CMD_NONE: ;
      default: begin
        hit = 1'b0;
        way = -1;
        wb  = 1'b0;
        wbs = '0;
        for (idx = 0; idx < NUM_ENTRIES; idx++)
          if (way < 0 && line_valid[idx] && line_sector[idx] == sector) way = idx;
        if (way >= 0) begin
          hit = 1'b1;
          line_ref[way] = 1'b1;
        end else begin
          // second chance sweep, hand steps past the victim too
          while (way < 0) begin
            if (!line_valid[sweep_pos]) way = sweep_pos;
            else if (line_ref[sweep_pos]) line_ref[sweep_pos] = 1'b0;
            else way = sweep_pos;
            sweep_pos = (sweep_pos + 1) % NUM_ENTRIES;
          end
          if (line_valid[way] && line_dirty[way]) begin
            wb  = 1'b1;
            wbs = line_sector[way];
          end
          line_valid[way]  = 1'b1;
          line_sector[way] = sector;
          line_dirty[way]  = 1'b0;
          line_ref[way]    = 1'b1;
        end
        if (cmd == CMD_WRITE) line_dirty[way] = 1'b1;
        step_out[0] = make_reply(hit, way, !hit, wb, wbs, 1'b1);
        step_n = 1;
      end
    endcase
  endtask

  // entered and left at a falling edge
  task automatic offer(input logic [1:0] cmd, input logic [31:0] sector,
                       input row_kind_t kind, input cache_reply_t fixed);
    int gap;
    int k;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({sector, cmd});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(cmd, sector);
    case (kind)
      KIND_MODEL: for (k = 0; k < step_n; k++) replies_due.push_back(step_out[k]);
      KIND_FIXED: replies_due.push_back(fixed);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic offer_mixed();
    int          pick;
    logic [1:0]  cmd;
    logic [31:0] sector;
    pick = $urandom_range(0, 99);
    if (pick < 45)      cmd = CMD_READ;
    else if (pick < 85) cmd = CMD_WRITE;
    else if (pick < 93) cmd = CMD_FLUSH;
    else                cmd = CMD_NONE;
    sector = ($urandom_range(0, 9) == 0) ? $urandom
                                         : sector_pool[$urandom_range(0, SECTOR_POOL-1)];
    offer(cmd, sector, KIND_MODEL, '0);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (replies_due.size() != 0);
  endtask

  task automatic add_row(input row_kind_t kind, input logic [1:0] cmd, input logic [31:0] sector,
                         input cache_reply_t reply);
    table_row_t row;
    row.kind   = kind;
    row.cmd    = cmd;
    row.sector = sector;
    row.reply  = reply;
    directed_rows.push_back(row);
  endtask

  // result checker
  always @(posedge clk) begin
    cache_reply_t got;
    cache_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.hit       = m_tdata[0];
      got.slot      = m_tdata[6:1];
      got.fill      = m_tdata[7];
      got.writeback = m_tdata[8];
      got.wb_sector = m_tdata[40:9];
      got.last      = m_tlast;
      if (replies_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected item: hit=%0b slot=%0d fill=%0b wb=%0b wb_sector=%h last=%0b",
                   got.hit, got.slot, got.fill, got.writeback, got.wb_sector, got.last);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (got.hit !== want.hit || got.slot !== want.slot || got.fill !== want.fill ||
            got.writeback !== want.writeback || got.wb_sector !== want.wb_sector ||
            got.last !== want.last) begin
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch exp: hit=%0b slot=%0d fill=%0b wb=%0b wb_sector=%h last=%0b",
                     want.hit, want.slot, want.fill, want.writeback, want.wb_sector, want.last);
            $display("         got: hit=%0b slot=%0d fill=%0b wb=%0b wb_sector=%h last=%0b",
                     got.hit, got.slot, got.fill, got.writeback, got.wb_sector, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: shifting ready pattern plus long hold-offs on request
  initial begin : receiver
    int          phase_left;
    int          hold_left;
    ready_mode_t mode;
    phase_left = 0;
    hold_left  = 0;
    mode       = READY_ALWAYS;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (phase_left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          READY_ALWAYS: m_tready <= 1'b1;
          READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
          default:      m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int tries;
    int idx;
    int lane;
    int n;

    add_row(KIND_FIXED, CMD_READ,  32'h0000_0000, make_reply(0, 0, 1, 0, 32'd0, 1));
    add_row(KIND_FIXED, CMD_FLUSH, 32'h0000_0000, make_reply(0, 0, 0, 0, 32'd0, 1));
    add_row(KIND_FIXED, CMD_WRITE, 32'hFFFF_FFFF, make_reply(0, 1, 1, 0, 32'd0, 1));
    add_row(KIND_FIXED, CMD_READ,  32'hFFFF_FFFF, make_reply(1, 1, 0, 0, 32'd0, 1));
    add_row(KIND_FIXED, CMD_FLUSH, 32'hFFFF_FFFF, make_reply(0, 1, 0, 1, 32'hFFFF_FFFF, 1));
    add_row(KIND_FIXED, CMD_FLUSH, 32'h1234_5678, make_reply(0, 0, 0, 0, 32'd0, 1));
    add_row(KIND_NONE,  CMD_NONE,  32'hAAAA_AAAA, '0);
    add_row(KIND_FIXED, CMD_WRITE, 32'h0000_0000, make_reply(1, 0, 0, 0, 32'd0, 1));
    add_row(KIND_FIXED, CMD_WRITE, 32'h5555_5555, make_reply(0, 2, 1, 0, 32'd0, 1));
    add_row(KIND_FIXED, CMD_WRITE, 32'hAAAA_AAAA, make_reply(0, 3, 1, 0, 32'd0, 1));
    add_row(KIND_NONE,  CMD_NONE,  32'h5555_5555, '0);
    add_row(KIND_FIXED, CMD_READ,  32'h8000_0000, make_reply(0, 4, 1, 0, 32'd0, 1));
    add_row(KIND_FIXED, CMD_WRITE, 32'h0000_0001, make_reply(0, 5, 1, 0, 32'd0, 1));
    add_row(KIND_MODEL, CMD_FLUSH, 32'hFFFF_FFFF, '0);
    add_row(KIND_FIXED, CMD_READ,  32'h5555_5555, make_reply(1, 2, 0, 0, 32'd0, 1));
    add_row(KIND_FIXED, CMD_FLUSH, 32'h0000_0000, make_reply(0, 0, 0, 0, 32'd0, 1));
    add_row(KIND_MODEL, CMD_WRITE, 32'h7FFF_FFFF, '0);
    add_row(KIND_MODEL, CMD_READ,  32'h0000_0001, '0);

    for (idx = 0; idx < SECTOR_POOL; idx++) sector_pool[idx] = $urandom;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer(directed_rows[i].cmd, directed_rows[i].sector, directed_rows[i].kind,
            directed_rows[i].reply);

    // let everything settle before the random traffic
    wait_idle();

    holds_asked++;
    for (n = 0; n < 60; n++) offer_mixed();

    // dirty every entry so the next flush reports the whole cache
    for (tries = 0; tries < 200; tries++) begin
      lane = -1;
      for (idx = 0; idx < NUM_ENTRIES; idx++)
        if (lane < 0 && !(line_valid[idx] && line_dirty[idx])) lane = idx;
      if (lane < 0) break;
      offer(CMD_WRITE, line_valid[lane] ? line_sector[lane] : $urandom, KIND_MODEL, '0);
    end

    holds_asked++;
    offer(CMD_FLUSH, $urandom, KIND_MODEL, '0);
    for (n = 0; n < 25; n++) offer_mixed();

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/scc_pkg.sv
rtl/scc_ram.sv
rtl/scc_datapath.sv
rtl/scc_ctrl.sv
rtl/sector_cache_clock_replacement.sv
bench/tb.sv
